// ===== rtl/core/oidl_pkg.sv =====
// Package for the ordered id list engine.
// Holds command/status codes, the controller state type and the cell control beat.
// No dependencies.
package oidl_pkg;

	localparam int DEPTH_DEF = 16;
	localparam int ID_W      = 32;
	localparam int DUR_W     = 32;
	localparam int POS_W     = 4;
	localparam int TOTAL_W   = 5;

	typedef enum logic [2:0] {
		CMD_INS_FRONT = 3'd0,
		CMD_INS_BACK  = 3'd1,
		CMD_REM_FIRST = 3'd2,
		CMD_REM_LAST  = 3'd3,
		CMD_REM_ID    = 3'd4,
		CMD_LIST      = 3'd5
	} cmd_t;

	typedef enum logic [1:0] {
		STS_OK        = 2'd0,
		STS_EMPTY     = 2'd1,
		STS_FULL      = 2'd2,
		STS_NOT_FOUND = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_LIST,
		ST_SEARCH
	} state_t;

	typedef enum logic [2:0] {
		OP_HOLD,
		OP_PUSH_FRONT,
		OP_PUSH_BACK,
		OP_DROP,
		OP_ROTATE
	} cell_op_t;

	typedef struct packed {
		cell_op_t          op;
		logic [ID_W-1:0]   id;
		logic [DUR_W-1:0]  dur;
	} cell_ctl_t;

endpackage

// ===== rtl/core/ordered_id_list_engine_unit.sv =====
// Ordered id list engine: row of entry cells, front cell first, driven by oidl_ctrl.
// Inserts and removes at an end: one result beat in the cycle after accept.
// List of N entries: N beats on consecutive cycles, one registered per ST_LIST step,
// the row rotating one position per cycle past cell 0; busy during the walk.
// Remove by id: each entry rotates past cell 0's comparator, then one beat; busy meanwhile.
// Reset clears the count and control; entry contents stay undefined, receiver cannot stall.
module ordered_id_list_engine_unit #(
	parameter int DEPTH = oidl_pkg::DEPTH_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                start,
	output logic                                busy,
	input  logic [2:0]                          command,
	input  logic signed [oidl_pkg::ID_W-1:0]    track_id,
	input  logic [oidl_pkg::DUR_W-1:0]          duration_bits,
	output logic                                result_valid,
	output logic [1:0]                          status,
	output logic                                entry_valid,
	output logic signed [oidl_pkg::ID_W-1:0]    entry_id,
	output logic [oidl_pkg::DUR_W-1:0]          entry_duration_bits,
	output logic [oidl_pkg::POS_W-1:0]          entry_position,
	output logic [oidl_pkg::TOTAL_W-1:0]        entry_total,
	output logic                                last
);

	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam int IDX_W = $clog2(DEPTH);

	oidl_pkg::cell_ctl_t        ctl;
	logic [CNT_W-1:0]           cnt;
	logic [oidl_pkg::ID_W-1:0]  cell_id  [DEPTH];
	logic [oidl_pkg::DUR_W-1:0] cell_dur [DEPTH];

	oidl_ctrl #(
		.DEPTH (DEPTH),
		.CNT_W (CNT_W),
		.IDX_W (IDX_W)
	) u_ctrl (
		.clk                 (clk),
		.arst_n              (arst_n),
		.start               (start),
		.busy                (busy),
		.command             (command),
		.track_id            (track_id),
		.duration_bits       (duration_bits),
		.front_id            (cell_id[0]),
		.front_dur           (cell_dur[0]),
		.ctl                 (ctl),
		.cnt                 (cnt),
		.result_valid        (result_valid),
		.status              (status),
		.entry_valid         (entry_valid),
		.entry_id            (entry_id),
		.entry_duration_bits (entry_duration_bits),
		.entry_position      (entry_position),
		.entry_total         (entry_total),
		.last                (last)
	);

	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		localparam int L = (i == 0) ? 0 : i - 1;
		localparam int R = (i == DEPTH - 1) ? i : i + 1;
		oidl_cell #(
			.IDX   (i),
			.CNT_W (CNT_W)
		) u_cell (
			.clk       (clk),
			.ctl       (ctl),
			.cnt       (cnt),
			.left_id   (cell_id[L]),
			.left_dur  (cell_dur[L]),
			.right_id  (cell_id[R]),
			.right_dur (cell_dur[R]),
			.front_id  (cell_id[0]),
			.front_dur (cell_dur[0]),
			.id        (cell_id[i]),
			.dur       (cell_dur[i])
		);
	end

endmodule

// ===== rtl/core/oidl_cell.sv =====
// One list cell: holds the entry at list position IDX.
// Depends on oidl_pkg (cell_ctl_t, cell_op_t).
module oidl_cell #(
	parameter int IDX   = 0,
	parameter int CNT_W = 5
) (
	input  logic                        clk,
	input  oidl_pkg::cell_ctl_t         ctl,
	input  logic [CNT_W-1:0]            cnt,
	input  logic [oidl_pkg::ID_W-1:0]   left_id,
	input  logic [oidl_pkg::DUR_W-1:0]  left_dur,
	input  logic [oidl_pkg::ID_W-1:0]   right_id,
	input  logic [oidl_pkg::DUR_W-1:0]  right_dur,
	input  logic [oidl_pkg::ID_W-1:0]   front_id,
	input  logic [oidl_pkg::DUR_W-1:0]  front_dur,
	output logic [oidl_pkg::ID_W-1:0]   id,
	output logic [oidl_pkg::DUR_W-1:0]  dur
);

	logic [oidl_pkg::ID_W-1:0]  id_q;
	logic [oidl_pkg::DUR_W-1:0] dur_q;
	logic [oidl_pkg::ID_W-1:0]  id_d;
	logic [oidl_pkg::DUR_W-1:0] dur_d;
	logic                       at_cnt;
	logic                       at_tail;

	assign at_cnt  = (cnt == CNT_W'(IDX));
	assign at_tail = (cnt == CNT_W'(IDX + 1));

	always_comb begin
		id_d  = id_q;
		dur_d = dur_q;
		case (ctl.op)
			oidl_pkg::OP_PUSH_FRONT: begin
				if (IDX == 0) begin
					id_d  = ctl.id;
					dur_d = ctl.dur;
				end else begin
					id_d  = left_id;
					dur_d = left_dur;
				end
			end
			oidl_pkg::OP_PUSH_BACK: begin
				if (at_cnt) begin
					id_d  = ctl.id;
					dur_d = ctl.dur;
				end
			end
			oidl_pkg::OP_DROP: begin
				id_d  = right_id;
				dur_d = right_dur;
			end
			oidl_pkg::OP_ROTATE: begin
				if (at_tail) begin
					id_d  = front_id;
					dur_d = front_dur;
				end else begin
					id_d  = right_id;
					dur_d = right_dur;
				end
			end
			default: begin
				id_d  = id_q;
				dur_d = dur_q;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		id_q  <= id_d;
		dur_q <= dur_d;
	end

	assign id  = id_q;
	assign dur = dur_q;

endmodule

// ===== rtl/core/oidl_ctrl.sv =====
// Command sequencer for the ordered id list engine: count, list and search walks,
// result register. Depends on oidl_pkg.
module oidl_ctrl #(
	parameter int DEPTH = oidl_pkg::DEPTH_DEF,
	parameter int CNT_W = $clog2(DEPTH + 1),
	parameter int IDX_W = $clog2(DEPTH)
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                start,
	output logic                                busy,
	input  logic [2:0]                          command,
	input  logic signed [oidl_pkg::ID_W-1:0]    track_id,
	input  logic [oidl_pkg::DUR_W-1:0]          duration_bits,
	input  logic [oidl_pkg::ID_W-1:0]           front_id,
	input  logic [oidl_pkg::DUR_W-1:0]          front_dur,
	output oidl_pkg::cell_ctl_t                 ctl,
	output logic [CNT_W-1:0]                    cnt,
	output logic                                result_valid,
	output logic [1:0]                          status,
	output logic                                entry_valid,
	output logic signed [oidl_pkg::ID_W-1:0]    entry_id,
	output logic [oidl_pkg::DUR_W-1:0]          entry_duration_bits,
	output logic [oidl_pkg::POS_W-1:0]          entry_position,
	output logic [oidl_pkg::TOTAL_W-1:0]        entry_total,
	output logic                                last
);

	oidl_pkg::state_t  state_q, state_d;
	oidl_pkg::cmd_t    cmd;
	oidl_pkg::cell_op_t op;
	logic [CNT_W-1:0]  cnt_q, cnt_d;
	logic [CNT_W-1:0]  steps_q;
	logic [IDX_W-1:0]  k_q, k_d;
	logic              found_q, found_d;
	logic [oidl_pkg::ID_W-1:0] target_q;
	logic              accept;
	logic              empty;
	logic              full;
	logic              list_end;
	logic              search_end;
	logic              hit;

	logic                        rv_d;
	oidl_pkg::status_t           sts_d;
	logic                        ev_d;
	logic [oidl_pkg::ID_W-1:0]   eid_d;
	logic [oidl_pkg::DUR_W-1:0]  edur_d;
	logic [31:0]                 pos_ext;
	logic [31:0]                 tot_ext;
	logic                        last_d;

	assign cmd        = oidl_pkg::cmd_t'(command);
	assign busy       = (state_q != oidl_pkg::ST_IDLE);
	assign accept     = start && !busy;
	assign empty      = (cnt_q == '0);
	assign full       = (cnt_q == CNT_W'(DEPTH));
	assign list_end   = (CNT_W'(k_q) + CNT_W'(1) == cnt_q);
	assign search_end = (CNT_W'(k_q) + CNT_W'(1) == steps_q);
	assign hit        = !found_q && (front_id == target_q);

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			oidl_pkg::ST_IDLE: begin
				if (accept && !empty) begin
					if (cmd == oidl_pkg::CMD_LIST)
						state_d = oidl_pkg::ST_LIST;
					else if (cmd == oidl_pkg::CMD_REM_ID)
						state_d = oidl_pkg::ST_SEARCH;
				end
			end
			oidl_pkg::ST_LIST: begin
				if (list_end)
					state_d = oidl_pkg::ST_IDLE;
			end
			oidl_pkg::ST_SEARCH: begin
				if (search_end)
					state_d = oidl_pkg::ST_IDLE;
			end
			default: begin
				state_d = oidl_pkg::ST_IDLE;
			end
		endcase
	end

	// cell control and result
	always_comb begin
		op      = oidl_pkg::OP_HOLD;
		cnt_d   = cnt_q;
		k_d     = k_q;
		found_d = found_q;
		rv_d    = 1'b0;
		sts_d   = oidl_pkg::STS_OK;
		ev_d    = 1'b0;
		eid_d   = '0;
		edur_d  = '0;
		pos_ext = '0;
		last_d  = 1'b1;
		unique case (state_q)
			oidl_pkg::ST_IDLE: begin
				if (accept) begin
					k_d     = '0;
					found_d = 1'b0;
					rv_d    = 1'b1;
					unique case (cmd)
						oidl_pkg::CMD_INS_FRONT, oidl_pkg::CMD_INS_BACK: begin
							if (full) begin
								sts_d = oidl_pkg::STS_FULL;
							end else begin
								op    = (cmd == oidl_pkg::CMD_INS_FRONT) ?
								        oidl_pkg::OP_PUSH_FRONT : oidl_pkg::OP_PUSH_BACK;
								cnt_d = cnt_q + CNT_W'(1);
							end
						end
						oidl_pkg::CMD_REM_FIRST: begin
							if (empty) begin
								sts_d = oidl_pkg::STS_EMPTY;
							end else begin
								op    = oidl_pkg::OP_DROP;
								cnt_d = cnt_q - CNT_W'(1);
							end
						end
						oidl_pkg::CMD_REM_LAST: begin
							if (empty)
								sts_d = oidl_pkg::STS_EMPTY;
							else
								cnt_d = cnt_q - CNT_W'(1);
						end
						oidl_pkg::CMD_REM_ID, oidl_pkg::CMD_LIST: begin
							if (empty)
								sts_d = oidl_pkg::STS_EMPTY;
							else
								rv_d = 1'b0;
						end
						default: begin
							sts_d = oidl_pkg::STS_OK;
						end
					endcase
				end
			end
			oidl_pkg::ST_LIST: begin
				op      = oidl_pkg::OP_ROTATE;
				k_d     = k_q + IDX_W'(1);
				rv_d    = 1'b1;
				ev_d    = 1'b1;
				eid_d   = front_id;
				edur_d  = front_dur;
				pos_ext = 32'(k_q);
				last_d  = list_end;
			end
			oidl_pkg::ST_SEARCH: begin
				k_d = k_q + IDX_W'(1);
				if (hit) begin
					op      = oidl_pkg::OP_DROP;
					cnt_d   = cnt_q - CNT_W'(1);
					found_d = 1'b1;
				end else begin
					op = oidl_pkg::OP_ROTATE;
				end
				if (search_end) begin
					rv_d  = 1'b1;
					sts_d = (found_q || hit) ? oidl_pkg::STS_OK : oidl_pkg::STS_NOT_FOUND;
				end
			end
			default: begin
				op = oidl_pkg::OP_HOLD;
			end
		endcase
	end

	assign tot_ext = 32'(cnt_d);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= oidl_pkg::ST_IDLE;
			cnt_q        <= '0;
			k_q          <= '0;
			found_q      <= 1'b0;
			result_valid <= 1'b0;
		end else begin
			state_q      <= state_d;
			cnt_q        <= cnt_d;
			k_q          <= k_d;
			found_q      <= found_d;
			result_valid <= rv_d;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			target_q <= track_id;
			steps_q  <= cnt_q;
		end
		status              <= sts_d;
		entry_valid         <= ev_d;
		entry_id            <= eid_d;
		entry_duration_bits <= edur_d;
		entry_position      <= pos_ext[oidl_pkg::POS_W-1:0];
		entry_total         <= tot_ext[oidl_pkg::TOTAL_W-1:0];
		last                <= last_d;
	end

	assign ctl.op  = op;
	assign ctl.id  = track_id;
	assign ctl.dur = duration_bits;
	assign cnt     = cnt_q;

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_W'(DEPTH))
		else $error("entry count above depth");

	a_list_beat: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == oidl_pkg::ST_LIST) |=> (result_valid && entry_valid))
		else $error("list walk step without an entry beat");

	a_single_beat: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && cmd != oidl_pkg::CMD_LIST && cmd != oidl_pkg::CMD_REM_ID)
		|=> (result_valid && last && !entry_valid))
		else $error("single-result command gave no closing beat");

	a_search_drop: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == oidl_pkg::ST_SEARCH)
		|=> (cnt_q == $past(cnt_q) || cnt_q == CNT_W'($past(cnt_q) - CNT_W'(1))))
		else $error("search step changed count by more than one");

	a_search_once: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == oidl_pkg::ST_SEARCH && found_q) |=> (cnt_q == $past(cnt_q)))
		else $error("search dropped a second entry");

endmodule

// ===== verif/tb.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for ordered_id_list_engine_unit: directed and random command
// streams, each result beat checked against an in-bench list predictor.
// Depends on oidl_pkg and the RTL of the engine only.
module tb;
	import oidl_pkg::*;

	localparam int          LIST_DEPTH    = DEPTH_DEF;
	localparam int unsigned CYCLE_LIMIT   = 200000;
	localparam logic [2:0]  CMD_UNUSED_LO = 3'd6;
	localparam logic [2:0]  CMD_UNUSED_HI = 3'd7;

	typedef struct {
		logic [1:0]        status;
		logic              valid;
		logic [ID_W-1:0]   id;
		logic [DUR_W-1:0]  dur;
		logic [POS_W-1:0]  pos;
		logic [TOTAL_W-1:0] total;
		logic              last_beat;
	} list_beat_t;

	logic                       clk = 1'b0;
	logic                       arst_n = 1'b0;
	logic                       start = 1'b0;
	logic                       busy;
	logic [2:0]                 command = '0;
	logic signed [ID_W-1:0]     track_id = '0;
	logic [DUR_W-1:0]           duration_bits = '0;
	logic                       result_valid;
	logic [1:0]                 status;
	logic                       entry_valid;
	logic signed [ID_W-1:0]     entry_id;
	logic [DUR_W-1:0]           entry_duration_bits;
	logic [POS_W-1:0]           entry_position;
	logic [TOTAL_W-1:0]         entry_total;
	logic                       last;

	logic [ID_W-1:0]  held_ids[$];
	logic [DUR_W-1:0] held_durs[$];
	list_beat_t       expected_beats[$];
	list_beat_t       want;
	int               error_count = 0;
	int               sender_idle_pct = 0;
	int unsigned      cycle_count = 0;

	ordered_id_list_engine_unit #(.DEPTH(LIST_DEPTH)) dut (
		.clk                 (clk),
		.arst_n              (arst_n),
		.start               (start),
		.busy                (busy),
		.command             (command),
		.track_id            (track_id),
		.duration_bits       (duration_bits),
		.result_valid        (result_valid),
		.status              (status),
		.entry_valid         (entry_valid),
		.entry_id            (entry_id),
		.entry_duration_bits (entry_duration_bits),
		.entry_position      (entry_position),
		.entry_total         (entry_total),
		.last                (last)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	always @(posedge clk) cycle_count <= cycle_count + 1;

	initial begin
		wait (cycle_count >= CYCLE_LIMIT);
		$display("RESULT: ERROR");
		$finish;
	end

	task automatic push_beat(input logic [1:0] sts, input logic vld, input logic [ID_W-1:0] id,
			input logic [DUR_W-1:0] dur, input int pos, input logic lst);
		list_beat_t b;
		b.status    = sts;
		b.valid     = vld;
		b.id        = id;
		b.dur       = dur;
		b.pos       = POS_W'(pos);
		b.total     = TOTAL_W'(held_ids.size());
		b.last_beat = lst;
		expected_beats.push_back(b);
	endtask

	// list predictor: updates the held entries and queues the beats one command yields
	task automatic predict_command(input logic [2:0] cmd, input logic [ID_W-1:0] id,
			input logic [DUR_W-1:0] dur);
		logic [1:0] sts;
		int         hit;
		sts = STS_OK;
		hit = -1;
		case (cmd)
			CMD_INS_FRONT, CMD_INS_BACK: begin
				if (held_ids.size() >= LIST_DEPTH) begin
					sts = STS_FULL;
				end else if (cmd == CMD_INS_FRONT) begin
					held_ids.push_front(id);
					held_durs.push_front(dur);
				end else begin
					held_ids.push_back(id);
					held_durs.push_back(dur);
				end
			end
			CMD_REM_FIRST: begin
				if (held_ids.size() == 0) begin
					sts = STS_EMPTY;
				end else begin
					void'(held_ids.pop_front());
					void'(held_durs.pop_front());
				end
			end
			CMD_REM_LAST: begin
				if (held_ids.size() == 0) begin
					sts = STS_EMPTY;
				end else begin
					void'(held_ids.pop_back());
					void'(held_durs.pop_back());
				end
			end
			CMD_REM_ID: begin
				if (held_ids.size() == 0) begin
					sts = STS_EMPTY;
				end else begin
					for (int i = 0; i < held_ids.size(); i++)
						if (hit < 0 && held_ids[i] == id) hit = i;
					if (hit < 0) begin
						sts = STS_NOT_FOUND;
					end else begin
						held_ids.delete(hit);
						held_durs.delete(hit);
					end
				end
			end
			CMD_LIST: begin
				if (held_ids.size() == 0) begin
					sts = STS_EMPTY;
				end else begin
					for (int p = 0; p < held_ids.size(); p++)
						push_beat(STS_OK, 1'b1, held_ids[p], held_durs[p], p,
							p == held_ids.size() - 1);
					return;
				end
			end
			default: ;
		endcase
		push_beat(sts, 1'b0, '0, '0, 0, 1'b1);
	endtask

	task automatic check_field(input string name, input logic [31:0] exp_v,
			input logic [31:0] act_v);
		if (act_v !== exp_v) begin
			$display("%0t ns: %s mismatch, expected %h, actual %h", $time, name, exp_v, act_v);
			error_count++;
		end
	endtask

	always @(posedge clk) begin
		if (arst_n && result_valid) begin
			if (expected_beats.size() == 0) begin
				$display("%0t ns: unexpected result beat, expected none, actual status %0d id %h",
					$time, status, entry_id);
				error_count++;
			end else begin
				want = expected_beats.pop_front();
				check_field("status", 32'(want.status), 32'(status));
				check_field("entry_valid", 32'(want.valid), 32'(entry_valid));
				check_field("entry_id", want.id, entry_id);
				check_field("entry_duration_bits", want.dur, entry_duration_bits);
				check_field("entry_position", 32'(want.pos), 32'(entry_position));
				check_field("entry_total", 32'(want.total), 32'(entry_total));
				check_field("last", 32'(want.last_beat), 32'(last));
			end
		end
	end

	// start stays high across back-to-back commands; idle cycles carry noise on the fields
	task automatic send_command(input logic [2:0] cmd, input logic [ID_W-1:0] id,
			input logic [DUR_W-1:0] dur);
		while ($urandom_range(99) < sender_idle_pct) begin
			@(negedge clk);
			start         <= 1'b0;
			command       <= 3'($urandom);
			track_id      <= $urandom;
			duration_bits <= $urandom;
		end
		@(negedge clk);
		start         <= 1'b1;
		command       <= cmd;
		track_id      <= id;
		duration_bits <= dur;
		@(posedge clk);
		while (busy) @(posedge clk);
		predict_command(cmd, id, dur);
	endtask

	task automatic wait_for_idle();
		@(negedge clk);
		start <= 1'b0;
		while (expected_beats.size() != 0) @(posedge clk);
	endtask

	function automatic logic [ID_W-1:0] random_id();
		case ($urandom_range(5))
			0:       return 32'h8000_0000;
			1:       return 32'h7fff_ffff;
			2, 3:    return 32'($urandom_range(7)) - 32'd4;
			default: return $urandom;
		endcase
	endfunction

	function automatic logic [2:0] pick_command(input bit growing);
		int roll;
		roll = $urandom_range(99);
		if (roll < 2) return roll[0] ? CMD_UNUSED_HI : CMD_UNUSED_LO;
		if (roll < 12) return CMD_LIST;
		if (roll < (growing ? 70 : 35))
			return $urandom_range(1) ? CMD_INS_BACK : CMD_INS_FRONT;
		if (roll < (growing ? 80 : 65)) return CMD_REM_ID;
		return $urandom_range(1) ? CMD_REM_LAST : CMD_REM_FIRST;
	endfunction

	task automatic test_empty_list();
		send_command(CMD_LIST, 32'd0, 32'd0);
		send_command(CMD_REM_FIRST, 32'd0, 32'd0);
		send_command(CMD_REM_LAST, 32'd0, 32'd0);
		send_command(CMD_REM_ID, 32'hffff_ffff, 32'hffff_ffff);
		send_command(CMD_UNUSED_LO, 32'h1234_5678, 32'h9abc_def0);
		send_command(CMD_UNUSED_HI, 32'h8000_0000, 32'hffff_ffff);
	endtask

	task automatic test_both_ends();
		send_command(CMD_INS_BACK, 32'h7fff_ffff, 32'hffff_ffff);
		send_command(CMD_INS_FRONT, 32'h8000_0000, 32'h0000_0000);
		send_command(CMD_INS_BACK, 32'h0000_0000, 32'h5555_5555);
		send_command(CMD_LIST, 32'd0, 32'd0);
		send_command(CMD_REM_ID, 32'h0000_3039, 32'd0);
		send_command(CMD_REM_ID, 32'h7fff_ffff, 32'd0);
		send_command(CMD_REM_FIRST, 32'd0, 32'd0);
		send_command(CMD_REM_LAST, 32'd0, 32'd0);
	endtask

	// fill to capacity with repeated ids, then refuse inserts, list, and remove the first match
	task automatic test_fill_to_capacity();
		for (int i = 0; i < LIST_DEPTH; i++)
			send_command(i[0] ? CMD_INS_BACK : CMD_INS_FRONT, 32'(i % 3), $urandom);
		send_command(CMD_INS_FRONT, 32'hffff_ffff, 32'hffff_ffff);
		send_command(CMD_INS_BACK, 32'hffff_ffff, 32'hffff_ffff);
		send_command(CMD_LIST, 32'd0, 32'd0);
		send_command(CMD_REM_ID, 32'd1, 32'd0);
	endtask

	task automatic run_random_phase(input int item_count, input int idle_pct);
		logic [2:0]      cmd;
		logic [ID_W-1:0] id;
		bit              growing;
		sender_idle_pct = idle_pct;
		growing = 1'b1;
		for (int n = 0; n < item_count; n++) begin
			if (held_ids.size() >= LIST_DEPTH) growing = 1'b0;
			else if (held_ids.size() == 0) growing = 1'b1;
			else if ($urandom_range(29) == 0) growing = !growing;
			cmd = pick_command(growing);
			id = random_id();
			if (cmd == CMD_REM_ID && held_ids.size() != 0 && $urandom_range(4) != 0)
				id = held_ids[$urandom_range(held_ids.size() - 1)];
			send_command(cmd, id, $urandom);
		end
	endtask

	task automatic test_random_traffic();
		run_random_phase(120, 0);
		wait_for_idle();
		run_random_phase(120, 88);
		wait_for_idle();
		run_random_phase(120, 25);
	endtask

	initial begin
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		test_empty_list();
		test_both_ends();
		wait_for_idle();
		test_fill_to_capacity();
		test_random_traffic();
		wait_for_idle();
		repeat (LIST_DEPTH + 4) @(posedge clk);
		if (error_count == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("RESULT: ERROR");
		end
		$finish;
	end

endmodule

// ===== ordered_id_list_engine_unit.f =====
rtl/core/oidl_pkg.sv
rtl/core/oidl_cell.sv
rtl/core/oidl_ctrl.sv
rtl/core/ordered_id_list_engine_unit.sv
verif/tb.sv
